// ===== design/rhs_pkg.sv =====
`timescale 1ns / 1ps

package rhs_pkg;

    localparam int ChanW  = 8;
    localparam int CodeW  = 8;
    localparam int KW     = 11;   // hue sector offset, 0 .. 6*delta-1
    localparam int SKW    = KW + 1;
    localparam int HNumW  = 18;   // 127 * k
    localparam int HDenW  = 10;   // 3 * delta
    localparam int SNumW  = 16;   // 254 * delta
    localparam int SDenW  = ChanW;
    localparam int NDiv   = CodeW;
    localparam int NStg   = 2 + NDiv;
    localparam int DataW  = 3 * ChanW;

    localparam logic [6:0] HueMul = 7'd127;  // 254*60/360 = 127/3
    localparam logic [1:0] HueDiv = 2'd3;
    localparam logic [7:0] SatMul = 8'd254;

    typedef struct packed {
        logic [HNumW-1:0] hnum;
        logic [HDenW-1:0] hden;
        logic [SNumW-1:0] snum;
        logic [SDenW-1:0] sden;
    } div_in_t;

endpackage

// ===== design/rgb_to_hue_saturation_codes.sv =====
`timescale 1ns / 1ps

// channel  dir  tdata (low bit up)                        tuser  tlast
// s_       in   red[7:0], green[15:8], blue[23:16]        -      -
// m_       out  hue_code[7:0], sat_code[15:8],            -      -
//               value_level[23:16]
//
// One pixel a cycle while m_ is not stalled; stages are extrema and hue sector, scaling
// multiplies, then eight restoring divider steps, one quotient bit each.
// aresetn clears the valid bits only; datapath registers are not reset.
// Every stage stalls on its own: a stage loads when empty or when the next
// one moves, so bubbles close up and a word waiting at m_ holds s_tready
// high until the pipeline is full.

module rgb_to_hue_saturation_codes (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rhs_pkg::DataW-1:0]   s_tdata,   // red, green, blue
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rhs_pkg::DataW-1:0]   m_tdata    // hue_code, sat_code, value_level
);

    localparam int NS = rhs_pkg::NStg;
    localparam int CW = rhs_pkg::ChanW;
    localparam int QW = rhs_pkg::CodeW;

    logic [NS-1:0] vld_reg, vld_next;
    logic [NS:0]   adv;

    rhs_pkg::div_in_t div_reg;

    logic [rhs_pkg::HNumW-1:0] hrem [0:rhs_pkg::NDiv];
    logic [rhs_pkg::HDenW-1:0] hden [0:rhs_pkg::NDiv];
    logic [QW-1:0]             hq   [0:rhs_pkg::NDiv];
    logic [rhs_pkg::SNumW-1:0] srem [0:rhs_pkg::NDiv];
    logic [rhs_pkg::SDenW-1:0] sden [0:rhs_pkg::NDiv];
    logic [QW-1:0]             sq   [0:rhs_pkg::NDiv];

    always_comb begin
        adv[NS] = m_tready;
        for (int i = NS - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NS; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    rhs_front u_front (
        .aclk    (aclk),
        .adv     (adv[1:0]),
        .red     (s_tdata[CW-1:0]),
        .green   (s_tdata[2*CW-1:CW]),
        .blue    (s_tdata[3*CW-1:2*CW]),
        .div_reg (div_reg)
    );

    assign hrem[0] = div_reg.hnum;
    assign hden[0] = div_reg.hden;
    assign hq[0]   = '0;
    assign srem[0] = div_reg.snum;
    assign sden[0] = div_reg.sden;
    assign sq[0]   = '0;

    for (genvar i = 0; i < rhs_pkg::NDiv; i++) begin : g_div
        rhs_div_step #(
            .NW (rhs_pkg::HNumW),
            .DW (rhs_pkg::HDenW),
            .SH (rhs_pkg::NDiv - 1 - i)
        ) u_hue (
            .aclk    (aclk),
            .adv     (adv[i+2]),
            .rem_in  (hrem[i]),
            .den_in  (hden[i]),
            .q_in    (hq[i]),
            .rem_reg (hrem[i+1]),
            .den_reg (hden[i+1]),
            .q_reg   (hq[i+1])
        );
        rhs_div_step #(
            .NW (rhs_pkg::SNumW),
            .DW (rhs_pkg::SDenW),
            .SH (rhs_pkg::NDiv - 1 - i)
        ) u_sat (
            .aclk    (aclk),
            .adv     (adv[i+2]),
            .rem_in  (srem[i]),
            .den_in  (sden[i]),
            .q_in    (sq[i]),
            .rem_reg (srem[i+1]),
            .den_reg (sden[i+1]),
            .q_reg   (sq[i+1])
        );
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {sden[rhs_pkg::NDiv], sq[rhs_pkg::NDiv], hq[rhs_pkg::NDiv]};

endmodule

// ===== design/rhs_front.sv =====
`timescale 1ns / 1ps

module rhs_front (
    input  logic                           aclk,
    input  logic [1:0]                     adv,
    input  logic [rhs_pkg::ChanW-1:0]      red,
    input  logic [rhs_pkg::ChanW-1:0]      green,
    input  logic [rhs_pkg::ChanW-1:0]      blue,
    output rhs_pkg::div_in_t               div_reg
);

    logic [rhs_pkg::ChanW-1:0] mx, mn, delta;
    logic signed [rhs_pkg::SKW-1:0] ks, sd;
    logic [rhs_pkg::KW-1:0]    k_next, k_reg;
    logic [rhs_pkg::ChanW-1:0] mx_reg, delta_reg;
    rhs_pkg::div_in_t          div_next;

    always_comb begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        delta = mx - mn;
        sd = $signed({4'd0, delta});
        if (mx == red) begin
            ks = $signed({4'd0, green}) - $signed({4'd0, blue});
        end else if (mx == green) begin
            ks = (sd <<< 1) + $signed({4'd0, blue}) - $signed({4'd0, red});
        end else begin
            ks = (sd <<< 2) + $signed({4'd0, red}) - $signed({4'd0, green});
        end
        if (ks < 0) ks = ks + (sd <<< 2) + (sd <<< 1);
        k_next = ks[rhs_pkg::KW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            k_reg     <= k_next;
            mx_reg    <= mx;
            delta_reg <= delta;
        end
    end

    always_comb begin
        div_next.hnum = rhs_pkg::HNumW'(k_reg * rhs_pkg::HueMul);
        div_next.hden = rhs_pkg::HDenW'(delta_reg * rhs_pkg::HueDiv);
        div_next.snum = rhs_pkg::SNumW'(delta_reg * rhs_pkg::SatMul);
        div_next.sden = mx_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            div_reg <= div_next;
        end
    end

endmodule

// ===== design/rhs_div_step.sv =====
`timescale 1ns / 1ps

module rhs_div_step #(
    parameter int NW = rhs_pkg::HNumW,
    parameter int DW = rhs_pkg::HDenW,
    parameter int SH = 0
) (
    input  logic                      aclk,
    input  logic                      adv,
    input  logic [NW-1:0]             rem_in,
    input  logic [DW-1:0]             den_in,
    input  logic [rhs_pkg::CodeW-1:0] q_in,
    output logic [NW-1:0]             rem_reg,
    output logic [DW-1:0]             den_reg,
    output logic [rhs_pkg::CodeW-1:0] q_reg
);

    localparam int CW = (NW > DW + rhs_pkg::CodeW) ? NW : DW + rhs_pkg::CodeW;

    logic [CW-1:0]             dsh, rext, diff;
    logic                      take;
    logic [NW-1:0]             rem_next;
    logic [rhs_pkg::CodeW-1:0] q_next;

    always_comb begin
        dsh  = CW'(den_in) << SH;
        rext = CW'(rem_in);
        diff = rext - dsh;
        // zero divisor never takes, so gray and black give zero
        take = (den_in != '0) && (rext >= dsh);
        rem_next = take ? diff[NW-1:0] : rem_in;
        q_next = q_in;
        q_next[SH] = take;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            q_reg   <= q_next;
        end
    end

endmodule

// ===== design/rhs_checker.sv =====
`timescale 1ns / 1ps

module rhs_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [rhs_pkg::DataW-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled with output free");

    a_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:0] != 8'd254 && m_tdata[7:0] != 8'd255)
        else $error("hue code out of range");

    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23:16] == 8'd0 |-> m_tdata[15:0] == 16'd0)
        else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hue_saturation_codes rhs_checker u_rhs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/tb_rgb_to_hue_saturation_codes.sv =====
`timescale 1ns / 1ps

module tb_rgb_to_hue_saturation_codes;

    localparam int RandomPixels = 1950;
    localparam int IdleLimit    = 4000;
    localparam int DrainCycles  = 24;

    typedef struct packed {
        logic [rhs_pkg::CodeW-1:0] hue;
        logic [rhs_pkg::CodeW-1:0] sat;
        logic [rhs_pkg::CodeW-1:0] val;
    } hsv_codes_t;

    typedef struct packed {
        logic [rhs_pkg::ChanW-1:0] red;
        logic [rhs_pkg::ChanW-1:0] green;
        logic [rhs_pkg::ChanW-1:0] blue;
        logic                      fixed;   // codes typed in, not predicted
        hsv_codes_t                codes;
    } pixel_row_t;

    typedef enum logic [1:0] {
        RxFlowing,
        RxCoinFlip,
        RxOneInFour,
        RxBursty
    } rx_mode_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [rhs_pkg::DataW-1:0] s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [rhs_pkg::DataW-1:0] m_tdata;

    hsv_codes_t  expected_codes_q[$];
    pixel_row_t  directed_rows[$];
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int          burst_left  = 0;

    rx_mode_t    rx_mode      = RxFlowing;
    int          rx_mode_left = 0;
    int unsigned rx_cycle     = 0;

    always #5 aclk = ~aclk;

    rgb_to_hue_saturation_codes u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic hsv_codes_t hsv_codes_of(input logic [rhs_pkg::ChanW-1:0] r, g, b);
        int rr, gg, bb, hi, lo, span, num;
        hsv_codes_t res;
        rr = int'(r);
        gg = int'(g);
        bb = int'(b);
        hi = rr;
        if (gg > hi) hi = gg;
        if (bb > hi) hi = bb;
        lo = rr;
        if (gg < lo) lo = gg;
        if (bb < lo) lo = bb;
        span = hi - lo;
        res = '0;
        if (span > 0) begin
            // sector priority: red, then green, then blue
            if (hi == rr) begin
                num = 60 * (gg - bb);
            end else if (hi == gg) begin
                num = 120 * span + 60 * (bb - rr);
            end else begin
                num = 240 * span + 60 * (rr - gg);
            end
            if (num < 0) num += 360 * span;
            res.hue = rhs_pkg::CodeW'((254 * num) / (360 * span));
        end
        if (hi > 0) res.sat = rhs_pkg::CodeW'((254 * span) / hi);
        res.val = rhs_pkg::CodeW'(hi);
        return res;
    endfunction

    task automatic add_row(input logic [rhs_pkg::ChanW-1:0] r, g, b, input logic fixed,
                           input logic [rhs_pkg::CodeW-1:0] h, s, v);
        pixel_row_t row;
        row.red   = r;
        row.green = g;
        row.blue  = b;
        row.fixed = fixed;
        row.codes = '{hue: h, sat: s, val: v};
        directed_rows.push_back(row);
    endtask

    // present one word, wait for the handshake, then pace the sender
    task automatic send_pixel(input logic [rhs_pkg::ChanW-1:0] r, g, b,
                              input hsv_codes_t want);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_codes_q.push_back(want);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (expected_codes_q.size() != 0) @(posedge aclk);
    endtask

    task automatic random_pixel(output logic [rhs_pkg::ChanW-1:0] r, g, b);
        logic [rhs_pkg::ChanW-1:0] x;
        r = rhs_pkg::ChanW'($urandom_range(0, 255));
        g = rhs_pkg::ChanW'($urandom_range(0, 255));
        b = rhs_pkg::ChanW'($urandom_range(0, 255));
        x = rhs_pkg::ChanW'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            5: begin
                g = r;
                b = r;
            end
            6: begin
                // two channels tie at the top
                case ($urandom_range(0, 2))
                    0: begin
                        r = x;
                        g = x;
                        b = rhs_pkg::ChanW'($urandom_range(0, x));
                    end
                    1: begin
                        g = x;
                        b = x;
                        r = rhs_pkg::ChanW'($urandom_range(0, x));
                    end
                    default: begin
                        r = x;
                        b = x;
                        g = rhs_pkg::ChanW'($urandom_range(0, x));
                    end
                endcase
            end
            7: begin
                r = rhs_pkg::ChanW'($urandom_range(0, 3));
                g = rhs_pkg::ChanW'($urandom_range(0, 3));
                b = rhs_pkg::ChanW'($urandom_range(0, 3));
            end
            8: begin
                r = rhs_pkg::ChanW'($urandom_range(252, 255));
                g = rhs_pkg::ChanW'($urandom_range(252, 255));
                b = rhs_pkg::ChanW'($urandom_range(252, 255));
            end
            9: begin
                r = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
            end
            default: ;
        endcase
    endtask

    initial begin
        pixel_row_t                row;
        logic [rhs_pkg::ChanW-1:0] r, g, b;

        add_row(8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'd0,   8'd0);    // black
        add_row(8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0,   8'd255);  // white
        add_row(8'd128, 8'd128, 8'd128, 1'b1, 8'd0, 8'd0,   8'd128);  // gray
        add_row(8'd1,   8'd1,   8'd1,   1'b1, 8'd0, 8'd0,   8'd1);
        add_row(8'd255, 8'd0,   8'd0,   1'b1, 8'd0, 8'd254, 8'd255);  // pure red
        add_row(8'd0,   8'd255, 8'd0,   1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd0,   8'd0,   8'd255, 1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd255, 8'd255, 8'd0,   1'b0, 8'd0, 8'd0,   8'd0);    // red/green tie
        add_row(8'd0,   8'd255, 8'd255, 1'b0, 8'd0, 8'd0,   8'd0);    // green/blue tie
        add_row(8'd255, 8'd0,   8'd255, 1'b0, 8'd0, 8'd0,   8'd0);    // red/blue tie
        add_row(8'd255, 8'd0,   8'd1,   1'b0, 8'd0, 8'd0,   8'd0);    // hue wraps
        add_row(8'd255, 8'd0,   8'd255, 1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd1,   8'd0,   8'd0,   1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd255, 8'd254, 8'd254, 1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd254, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd200, 8'd100, 8'd50,  1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd50,  8'd200, 8'd100, 1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd100, 8'd50,  8'd200, 1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd1,   8'd0,   8'd255, 1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd255, 8'd1,   8'd0,   1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd0,   8'd0,   8'd1,   1'b0, 8'd0, 8'd0,   8'd0);
        add_row(8'd170, 8'd85,  8'd0,   1'b0, 8'd0, 8'd0,   8'd0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_pixel(row.red, row.green, row.blue,
                       row.fixed ? row.codes : hsv_codes_of(row.red, row.green, row.blue));
        end
        hold_until_drained();

        for (int n = 0; n < RandomPixels; n++) begin
            if (n == RandomPixels / 2) hold_until_drained();
            random_pixel(r, g, b);
            send_pixel(r, g, b, hsv_codes_of(r, g, b));
        end

        hold_until_drained();
        repeat (DrainCycles) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    always @(posedge aclk) begin : rx_check
        hsv_codes_t want;
        hsv_codes_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.hue = m_tdata[7:0];
            got.sat = m_tdata[15:8];
            got.val = m_tdata[23:16];
            if (expected_codes_q.size() == 0) begin
                $error("unexpected word %h", m_tdata);
                mismatches++;
            end else begin
                want = expected_codes_q.pop_front();
                if (got.hue !== want.hue) begin
                    $error("hue_code: expected %0d, got %0d", want.hue, got.hue);
                    mismatches++;
                end
                if (got.sat !== want.sat) begin
                    $error("sat_code: expected %0d, got %0d", want.sat, got.sat);
                    mismatches++;
                end
                if (got.val !== want.val) begin
                    $error("value_level: expected %0d, got %0d", want.val, got.val);
                    mismatches++;
                end
            end
        end

        rx_cycle++;
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(50, 400);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RxFlowing:   m_tready <= 1'b1;
            RxCoinFlip:  m_tready <= 1'($urandom_range(0, 1));
            RxOneInFour: m_tready <= (rx_cycle % 4) == 0;
            default:     m_tready <= (rx_cycle % 9) < 5;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
